@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion shorthands, clocked on clk, off during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/cda_pkg.sv @@
// ----------------------------------------------------------------------------
// cda_pkg
// Types, constants, calendar helpers and the control store of the date adder.
// ----------------------------------------------------------------------------
package cda_pkg;

  // Field widths and calendar limits
  localparam int AMOUNT_W = 15;
  localparam logic [15:0] YEAR_MAX = 16'd32767;
  localparam logic [17:0] DAYS_400Y = 18'd146097;
  localparam logic [15:0] YEARS_400 = 16'd400;
  localparam logic [15:0] RECIP_400 = 16'd41944;  // 2^24 / 400, rounded up
  localparam logic [15:0] RECIP_12 = 16'd43691;   // 2^19 / 12, rounded up
  localparam logic [4:0] MAX_CLAMP_STEPS = 5'd24;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;
  localparam logic [4:0] DAY_LEAP = 5'd29;
  localparam logic [4:0] DAY_FEB_COMMON = 5'd28;
  localparam logic [4:0] DAY_LAST_DEC = 5'd31;

  localparam logic [4:0] MONTH_LEN [0:11] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Command codes
  localparam logic [2:0] CMD_DAYS = 3'd0;
  localparam logic [2:0] CMD_WEEKS = 3'd1;
  localparam logic [2:0] CMD_MONTHS = 3'd2;
  localparam logic [2:0] CMD_YEARS_STEP = 3'd3;
  localparam logic [2:0] CMD_YEARS_DIRECT = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  // Datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL_Y,
    OP_MOD_Y,
    OP_CHECK,
    OP_DSKIP,
    OP_DWALK,
    OP_MUL_N,
    OP_MFIN,
    OP_MWALK,
    OP_MCOPY,
    OP_YADD,
    OP_YCLAMP,
    OP_EMIT
  } op_t;

  // Branch conditions of the sequencer
  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_START,
    C_CHECK,
    C_SAT,
    C_DONE,
    C_CNT,
    C_EMIT
  } cond_t;

  typedef logic [3:0] uaddr_t;

  typedef struct packed {
    op_t    op;
    cond_t  cond;
    uaddr_t target;
  } uword_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic       start;
    logic       skip;
    logic       sat;
    logic       done;
    logic       cnt_one;
    logic       emit_ok;
    logic [2:0] cmd;
  } dp_flags_t;

  // Control store addresses
  localparam uaddr_t A_WAIT = 4'd0;
  localparam uaddr_t A_MULY = 4'd1;
  localparam uaddr_t A_MODY = 4'd2;
  localparam uaddr_t A_CHECK = 4'd3;
  localparam uaddr_t A_DSKIP = 4'd4;
  localparam uaddr_t A_DWALK = 4'd5;
  localparam uaddr_t A_MMUL = 4'd6;
  localparam uaddr_t A_MFIN = 4'd7;
  localparam uaddr_t A_MWALK = 4'd8;
  localparam uaddr_t A_MCOPY = 4'd9;
  localparam uaddr_t A_YADD = 4'd10;
  localparam uaddr_t A_YMUL = 4'd11;
  localparam uaddr_t A_YMOD = 4'd12;
  localparam uaddr_t A_YCLAMP = 4'd13;
  localparam uaddr_t A_FINISH = 4'd14;

  // Control store contents
  function automatic uword_t ucode_rom(input uaddr_t addr);
    uword_t w;
    unique case (addr)
      A_WAIT:   w = uword_t'{OP_LOAD,   C_START, A_WAIT};
      A_MULY:   w = uword_t'{OP_MUL_Y,  C_NEXT,  A_WAIT};
      A_MODY:   w = uword_t'{OP_MOD_Y,  C_NEXT,  A_WAIT};
      A_CHECK:  w = uword_t'{OP_CHECK,  C_CHECK, A_FINISH};
      A_DSKIP:  w = uword_t'{OP_DSKIP,  C_SAT,   A_FINISH};
      A_DWALK:  w = uword_t'{OP_DWALK,  C_DONE,  A_FINISH};
      A_MMUL:   w = uword_t'{OP_MUL_N,  C_NEXT,  A_WAIT};
      A_MFIN:   w = uword_t'{OP_MFIN,   C_SAT,   A_FINISH};
      A_MWALK:  w = uword_t'{OP_MWALK,  C_CNT,   A_MCOPY};
      A_MCOPY:  w = uword_t'{OP_MCOPY,  C_JUMP,  A_FINISH};
      A_YADD:   w = uword_t'{OP_YADD,   C_NEXT,  A_WAIT};
      A_YMUL:   w = uword_t'{OP_MUL_Y,  C_NEXT,  A_WAIT};
      A_YMOD:   w = uword_t'{OP_MOD_Y,  C_NEXT,  A_WAIT};
      A_YCLAMP: w = uword_t'{OP_YCLAMP, C_JUMP,  A_FINISH};
      A_FINISH: w = uword_t'{OP_EMIT,   C_EMIT,  A_WAIT};
      default:  w = uword_t'{OP_NOP,    C_JUMP,  A_WAIT};
    endcase
    return w;
  endfunction

  // Leap year from the year modulo 400
  function automatic logic is_leap(input logic [8:0] r400);
    return (r400 == 9'd0) ||
           ((r400[1:0] == 2'b00) && (r400 != 9'd100) && (r400 != 9'd200) &&
            (r400 != 9'd300));
  endfunction

  // Month length; zero for a month code outside 1..12
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [3:0] idx;
    logic [4:0] len;
    idx = m - 4'd1;
    if (m == 4'd0 || m > MONTH_DEC) begin
      len = 5'd0;
    end else if (m == MONTH_FEB && leap) begin
      len = DAY_LEAP;
    end else begin
      len = MONTH_LEN[idx];
    end
    return len;
  endfunction

endpackage

@@ hdl/cda_useq.sv @@
// ----------------------------------------------------------------------------
// cda_useq
// Micro-sequencer: step counter, control store lookup and branch logic.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cda_useq (
  input  logic               clk,
  input  logic               rst,
  input  cda_pkg::dp_flags_t flags,
  output cda_pkg::op_t       op,
  output logic               in_ready
);
  import cda_pkg::*;

  uaddr_t upc;
  uaddr_t upc_next;
  uword_t uword;

  // Fetch the current control word
  assign uword = ucode_rom(upc);

  // Select the next step
  always_comb begin
    unique case (uword.cond)
      C_NEXT:  upc_next = upc + 4'd1;
      C_JUMP:  upc_next = uword.target;
      C_START: upc_next = flags.start ? upc + 4'd1 : upc;
      C_CHECK: begin
        if (flags.skip) begin
          upc_next = uword.target;
        end else begin
          unique case (flags.cmd) inside
            CMD_DAYS, CMD_WEEKS:              upc_next = A_DSKIP;
            CMD_MONTHS:                       upc_next = A_MMUL;
            CMD_YEARS_STEP, CMD_YEARS_DIRECT: upc_next = A_YADD;
            default:                          upc_next = uword.target;
          endcase
        end
      end
      C_SAT:   upc_next = flags.sat ? uword.target : upc + 4'd1;
      C_DONE:  upc_next = flags.done ? uword.target : upc;
      C_CNT:   upc_next = flags.cnt_one ? uword.target : upc;
      C_EMIT:  upc_next = flags.emit_ok ? uword.target : upc;
      default: upc_next = A_WAIT;
    endcase
  end

  // Drive the datapath and the input handshake
  always_comb begin
    op       = uword.op;
    in_ready = (upc == A_WAIT);
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= A_WAIT;
    end else begin
      upc <= upc_next;
    end
  end

  `ASSERT_NEXT(a_accept_starts_program, flags.start && in_ready, upc == A_MULY,
               "accepted word did not start the program")
  `ASSERT_NEXT(a_emit_returns_to_wait, upc == A_FINISH && flags.emit_ok, upc == A_WAIT,
               "sequencer did not return to wait after emitting")

endmodule

@@ hdl/cda_dpath.sv @@
// ----------------------------------------------------------------------------
// cda_dpath
// Date datapath: date registers, shared reciprocal multiplier, month walker
// and the output register, all steered by one operation code per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cda_dpath #(
  parameter int AMOUNT_BITS = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  cda_pkg::op_t       op,
  input  logic               in_valid,
  input  logic [2:0]         cmd,
  input  logic [4:0]         day_in,
  input  logic [3:0]         month_in,
  input  logic [14:0]        year_in,
  input  logic [14:0]        amount,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [4:0]         day_out,
  output logic [3:0]         month_out,
  output logic [14:0]        year_out,
  output logic [1:0]         status,
  output cda_pkg::dp_flags_t flags
);
  import cda_pkg::*;

  localparam logic [AMOUNT_W-1:0] AMT_MASK = (AMOUNT_BITS >= AMOUNT_W) ?
      {AMOUNT_W{1'b1}} : AMOUNT_W'((32'd1 << AMOUNT_BITS) - 32'd1);

  // Working registers
  logic [2:0]  cmd_r;
  logic [4:0]  day;
  logic [3:0]  mon;
  logic [15:0] yr;
  logic [8:0]  yr400;
  logic [14:0] amt;
  logic [17:0] rem;
  logic [4:0]  cnt;
  logic [3:0]  fm;
  logic [15:0] fy;
  logic [1:0]  st;
  logic [30:0] prod;

  // Input staging
  logic [14:0] amt_in;
  logic [17:0] amt_ext;
  logic [17:0] rem_init;

  // Current month
  logic        leap_cur;
  logic [4:0]  len_cur;
  logic        invalid;

  // Next month
  logic [3:0]  adv_mon;
  logic [15:0] adv_yr;
  logic [8:0]  adv_r400;
  logic [4:0]  adv_len;

  // Day walk
  logic [4:0]  gap;
  logic        fits;
  logic        at_end;
  logic        big;
  logic [15:0] skip_yr;
  logic        skip_ovf;

  // Multiplier and reductions
  logic [14:0] mul_a;
  logic [15:0] mul_b;
  logic [6:0]  q400;
  logic [15:0] q400x;
  logic [15:0] mod_res;
  logic [11:0] q12;
  logic [14:0] q12x;
  logic [14:0] r12;
  logic [4:0]  mm;
  logic        wrap;
  logic [3:0]  fm_val;
  logic [15:0] fy_sum;
  logic        month_ovf;

  // Year add
  logic [15:0] ysum;
  logic        yovf;

  // Mask the count and scale weeks to days
  always_comb begin
    amt_in   = amount & AMT_MASK;
    amt_ext  = {3'b000, amt_in};
    rem_init = (cmd == CMD_WEEKS) ? ({amt_ext[14:0], 3'b000} - amt_ext) : amt_ext;
  end

  // Look up the current month and validate the date
  always_comb begin
    leap_cur = is_leap(yr400);
    len_cur  = month_days(mon, leap_cur);
    invalid  = (mon == 4'd0) || (mon > MONTH_DEC) || (day == 5'd0) || (day > len_cur);
  end

  // Step to the following month
  always_comb begin
    if (mon == MONTH_DEC) begin
      adv_mon  = 4'd1;
      adv_yr   = yr + 16'd1;
      adv_r400 = (yr400 == 9'd399) ? 9'd0 : yr400 + 9'd1;
    end else begin
      adv_mon  = mon + 4'd1;
      adv_yr   = yr;
      adv_r400 = yr400;
    end
    adv_len = month_days(adv_mon, is_leap(adv_r400));
  end

  // Day walk and 400-year skip
  always_comb begin
    gap      = len_cur - day;
    fits     = rem <= {13'd0, gap};
    at_end   = (mon == MONTH_DEC) && (yr == YEAR_MAX);
    big      = rem >= DAYS_400Y;
    skip_yr  = yr + YEARS_400;
    skip_ovf = skip_yr > YEAR_MAX;
  end

  // Reduce the product: year mod 400, and the count split into years and months
  always_comb begin
    mul_a     = (op == OP_MUL_N) ? amt : yr[14:0];
    mul_b     = (op == OP_MUL_N) ? RECIP_12 : RECIP_400;
    q400      = prod[30:24];
    q400x     = ({9'd0, q400} << 8) + ({9'd0, q400} << 7) + ({9'd0, q400} << 4);
    mod_res   = yr - q400x;
    q12       = prod[30:19];
    q12x      = ({3'd0, q12} << 3) + ({3'd0, q12} << 2);
    r12       = amt - q12x;
    mm        = {1'b0, mon} + {1'b0, r12[3:0]};
    wrap      = mm > {1'b0, MONTH_DEC};
    fm_val    = wrap ? 4'(mm - {1'b0, MONTH_DEC}) : mm[3:0];
    fy_sum    = yr + {4'd0, q12} + {15'd0, wrap};
    month_ovf = fy_sum > YEAR_MAX;
  end

  // Direct year add
  always_comb begin
    ysum = yr + {1'b0, amt};
    yovf = ysum > YEAR_MAX;
  end

  // Report status to the sequencer
  always_comb begin
    flags.start   = in_valid;
    flags.skip    = invalid || (amt == 15'd0);
    flags.sat     = (op == OP_DSKIP) ? (big && skip_ovf) : month_ovf;
    flags.done    = fits || at_end;
    flags.cnt_one = (cnt == 5'd1);
    flags.emit_ok = !out_valid || out_ready;
    flags.cmd     = cmd_r;
  end

  // Execute the operation of this step
  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        if (in_valid) begin
          cmd_r <= cmd;
          day   <= day_in;
          mon   <= month_in;
          yr    <= {1'b0, year_in};
          amt   <= amt_in;
          rem   <= rem_init;
          st    <= ST_OK;
        end
      end
      OP_MUL_Y, OP_MUL_N: begin
        prod <= 31'(mul_a) * 31'(mul_b);
      end
      OP_MOD_Y: begin
        yr400 <= mod_res[8:0];
      end
      OP_CHECK: begin
        if (invalid) begin
          st <= ST_INVALID;
        end
      end
      OP_DSKIP: begin
        if (big) begin
          if (skip_ovf) begin
            day <= DAY_LAST_DEC;
            mon <= MONTH_DEC;
            yr  <= YEAR_MAX;
            st  <= ST_SAT;
          end else begin
            yr  <= skip_yr;
            rem <= rem - DAYS_400Y;
          end
        end
      end
      OP_DWALK: begin
        if (fits) begin
          day <= day + rem[4:0];
        end else if (at_end) begin
          day <= DAY_LAST_DEC;
          mon <= MONTH_DEC;
          yr  <= YEAR_MAX;
          st  <= ST_SAT;
        end else begin
          rem   <= rem - ({13'd0, gap} + 18'd1);
          day   <= 5'd1;
          mon   <= adv_mon;
          yr    <= adv_yr;
          yr400 <= adv_r400;
        end
      end
      OP_MFIN: begin
        if (month_ovf) begin
          day <= DAY_LAST_DEC;
          mon <= MONTH_DEC;
          yr  <= YEAR_MAX;
          st  <= ST_SAT;
        end else begin
          fm  <= fm_val;
          fy  <= fy_sum;
          cnt <= (amt >= 15'(MAX_CLAMP_STEPS)) ? MAX_CLAMP_STEPS : amt[4:0];
        end
      end
      OP_MWALK: begin
        mon   <= adv_mon;
        yr    <= adv_yr;
        yr400 <= adv_r400;
        day   <= (day > adv_len) ? adv_len : day;
        cnt   <= cnt - 5'd1;
      end
      OP_MCOPY: begin
        mon <= fm;
        yr  <= fy;
      end
      OP_YADD: begin
        if (yovf) begin
          yr <= YEAR_MAX;
          st <= ST_SAT;
        end else begin
          yr <= ysum;
        end
        // A stepwise add always passes a common year
        if (cmd_r == CMD_YEARS_STEP && mon == MONTH_FEB && day == DAY_LEAP) begin
          day <= DAY_FEB_COMMON;
        end
      end
      OP_YCLAMP: begin
        if (day > len_cur) begin
          day <= len_cur;
        end
      end
      default: begin
      end
    endcase
  end

  // Hold the result word until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == OP_EMIT && flags.emit_ok) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Capture the result payload
  always_ff @(posedge clk) begin
    if (op == OP_EMIT && flags.emit_ok) begin
      day_out   <= day;
      month_out <= mon;
      year_out  <= yr[14:0];
      status    <= st;
    end
  end

  `ASSERT_IMPLY(a_walk_day_in_month, op == OP_DWALK,
                day != 5'd0 && day <= len_cur, "day walk left the current month")
  `ASSERT_IMPLY(a_clamp_count_range, op == OP_MWALK,
                cnt != 5'd0 && cnt <= MAX_CLAMP_STEPS, "month clamp count out of range")

endmodule

@@ hdl/calendar_date_adder_core.sv @@
// ----------------------------------------------------------------------------
// calendar_date_adder_core
// Adds days, weeks, months or years to a Gregorian date.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one word: cmd, day_in, month_in,
//   year_in and amount. Output channel (out_valid/out_ready) returns one word
//   per input: day_out, month_out, year_out and status.
//   A small program in a control store runs each word through the datapath,
//   one control word per cycle. in_ready is high only while the program
//   waits at its first step, so one word is in work at a time.
//   The result turns valid as in_ready returns high. Steps per word, after
//   the year is reduced modulo 400 and the date is checked:
//     invalid date, zero amount or unknown command: straight to the result
//     year commands: add the years, reduce the new year, clamp the day
//     month command: saturate if the year overflows, else walk min(amount, 24)
//     months clamping the day; day and week commands: skip a 400-year span
//     if the count holds one, saturating on overflow, then walk month by month
//   The result sits in an output register, so a stalled receiver holds only
//   the final step; the next word is accepted and computed meanwhile.
//   Reset clears the step counter and out_valid; no data needs clearing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module calendar_date_adder_core #(
  parameter int AMOUNT_BITS = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [4:0]  day_in,
  input  logic [3:0]  month_in,
  input  logic [14:0] year_in,
  input  logic [14:0] amount,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  day_out,
  output logic [3:0]  month_out,
  output logic [14:0] year_out,
  output logic [1:0]  status
);
  import cda_pkg::*;

  op_t       op;
  dp_flags_t flags;

  // Sequencer
  cda_useq u_useq (
    .clk      (clk),
    .rst      (rst),
    .flags    (flags),
    .op       (op),
    .in_ready (in_ready)
  );

  // Datapath
  cda_dpath #(
    .AMOUNT_BITS (AMOUNT_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .in_valid  (in_valid),
    .cmd       (cmd),
    .day_in    (day_in),
    .month_in  (month_in),
    .year_in   (year_in),
    .amount    (amount),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .day_out   (day_out),
    .month_out (month_out),
    .year_out  (year_out),
    .status    (status),
    .flags     (flags)
  );

  `ASSERT_IMPLY(a_sat_year_is_max, out_valid && status == ST_SAT,
                year_out == YEAR_MAX[14:0], "saturated result without maximum year")

endmodule

@@ tb/sv/tb_calendar_date_adder_core.sv @@
// ----------------------------------------------------------------------------
// tb_calendar_date_adder_core
// Self-checking bench for the calendar date adder. Every accepted input word
// runs through a cycle-free calendar model held in a scoreboard class.
// Result words are compared field by field in order of arrival. Stimulus is
// a directed set of calendar corner cases, then random words. Both sides of
// the block idle and stall at random.
// ----------------------------------------------------------------------------
module tb_calendar_date_adder_core;
  timeunit 1ns;
  timeprecision 1ps;

  import cda_pkg::*;

  localparam int          CLK_PERIOD    = 10;
  localparam int          RESET_CYCLES  = 9;
  localparam int unsigned RANDOM_WORDS  = 1200;
  localparam int unsigned DRAIN_EVERY   = 300;
  localparam int          SETTLE_CYCLES = 64;
  // Far above a real run, long week walks and stalls included
  localparam longint unsigned CYCLE_LIMIT = 64'd20_000_000;

  // Command codes the block treats as no-ops
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  typedef longint unsigned day_count_t;

  localparam day_count_t YEAR_LAST = day_count_t'(YEAR_MAX);
  localparam day_count_t DAYS_PER_MONTH [12] = '{
    31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31
  };

  typedef struct packed {
    logic [2:0]  cmd;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [14:0] year;
    logic [14:0] amount;
  } date_word_t;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [14:0] year;
    logic [1:0]  status;
  } date_result_t;

  // Gregorian leap rule; year 0 is a leap year
  function automatic bit is_leap_year(input day_count_t y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  // Zero for a month code outside 1..12
  function automatic day_count_t month_length(input day_count_t m, input day_count_t y);
    if (m < 1 || m > 12) return 0;
    if (m == 2 && is_leap_year(y)) return 29;
    return DAYS_PER_MONTH[m - 1];
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: predicts each accepted word, checks results in order
  // --------------------------------------------------------------------------
  class date_scoreboard;
    date_result_t expected_dates[$];
    int unsigned  mismatches;

    // Days since 1 March of year -400, offset keeps everything unsigned
    function day_count_t day_number(input day_count_t y, input day_count_t m,
                                    input day_count_t d);
      day_count_t yy, era, yoe, mp, doy, doe;
      yy  = y + 400 - ((m <= 2) ? 1 : 0);
      era = yy / 400;
      yoe = yy - era * 400;
      mp  = (m + 9) % 12;
      doy = (153 * mp + 2) / 5 + d - 1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      return era * 146097 + doe;
    endfunction

    function void date_of_number(input day_count_t z, output day_count_t y,
                                 output day_count_t m, output day_count_t d);
      day_count_t era, doe, yoe, doy, mp;
      era = z / 146097;
      doe = z - era * 146097;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp  = (5 * doy + 2) / 153;
      m   = (mp < 10) ? mp + 3 : mp - 9;
      d   = doy - (153 * mp + 2) / 5 + 1;
      y   = yoe + era * 400 + ((m <= 2) ? 1 : 0) - 400;
    endfunction

    function date_result_t advance_date(input date_word_t w);
      day_count_t   d, m, y, n, z, t, ny, k, i;
      logic [1:0]   st;
      date_result_t r;
      d  = w.day;
      m  = w.month;
      y  = w.year;
      n  = w.amount;
      st = ST_OK;
      // Flag a bad date before looking at the command
      if (m < 1 || m > 12 || d < 1 || d > month_length(m, y)) begin
        st = ST_INVALID;
      end else if (w.cmd == CMD_DAYS || w.cmd == CMD_WEEKS) begin
        z = day_number(y, m, d) + ((w.cmd == CMD_WEEKS) ? n * 7 : n);
        if (z > day_number(YEAR_LAST, 12, 31)) begin
          y = YEAR_LAST; m = 12; d = 31; st = ST_SAT;
        end else begin
          date_of_number(z, y, m, d);
        end
      end else if (w.cmd == CMD_MONTHS) begin
        t = y * 12 + (m - 1) + n;
        if (t > YEAR_LAST * 12 + 11) begin
          y = YEAR_LAST; m = 12; d = 31; st = ST_SAT;
        end else begin
          // Clamp the day at each month; 24 steps always pass a short February
          k = (n < 24) ? n : 24;
          for (i = 0; i < k; i++) begin
            if (m == 12) begin
              m = 1;
              y++;
            end else begin
              m++;
            end
            if (d > month_length(m, y)) d = month_length(m, y);
          end
          y = t / 12;
          m = t % 12 + 1;
        end
      end else if (w.cmd == CMD_YEARS_STEP || w.cmd == CMD_YEARS_DIRECT) begin
        ny = y + n;
        if (ny > YEAR_LAST) begin
          ny = YEAR_LAST;
          st = ST_SAT;
        end
        // Stepping from a leap day lands on a common year after at most two
        if (w.cmd == CMD_YEARS_STEP && m == 2 && d == 29 && n > 0) begin
          if (n >= 2 || !is_leap_year(y + 1)) d = 28;
        end
        y = ny;
        if (d > month_length(m, y)) d = month_length(m, y);
      end
      r.day    = 5'(d);
      r.month  = 4'(m);
      r.year   = 15'(y);
      r.status = st;
      return r;
    endfunction

    function void note_word(input date_word_t w);
      expected_dates.push_back(advance_date(w));
    endfunction

    function void compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_word(input date_result_t got);
      date_result_t want;
      if (expected_dates.size() == 0) begin
        $error("result word %0d/%0d/%0d status %0d with nothing outstanding",
               got.day, got.month, got.year, got.status);
        mismatches++;
        return;
      end
      want = expected_dates.pop_front();
      compare_field("day_out", want.day, got.day);
      compare_field("month_out", want.month, got.month);
      compare_field("year_out", want.year, got.year);
      compare_field("status", want.status, got.status);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  cmd;
  logic [4:0]  day_in;
  logic [3:0]  month_in;
  logic [14:0] year_in;
  logic [14:0] amount;
  logic        out_valid;
  logic        out_ready;
  logic [4:0]  day_out;
  logic [3:0]  month_out;
  logic [14:0] year_out;
  logic [1:0]  status;

  date_scoreboard  sb;
  bit              tx_steady;
  longint unsigned cycle_count = 0;

  calendar_date_adder_core #(
    .AMOUNT_BITS(AMOUNT_W)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .day_in    (day_in),
    .month_in  (month_in),
    .year_in   (year_in),
    .amount    (amount),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .day_out   (day_out),
    .month_out (month_out),
    .year_out  (year_out),
    .status    (status)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic date_word_t make_word(input logic [2:0] c, input int unsigned d,
                                           input int unsigned m, input int unsigned y,
                                           input int unsigned n);
    date_word_t w;
    w.cmd    = c;
    w.day    = 5'(d);
    w.month  = 4'(m);
    w.year   = 15'(y);
    w.amount = 15'(n);
    return w;
  endfunction

  // Many modern dates, some far out, some near the year ceiling
  function automatic date_word_t random_word();
    date_word_t  w;
    int unsigned pick;
    day_count_t  len;
    pick = $urandom_range(0, 99);
    if (pick < 92) w.cmd = 3'($urandom_range(CMD_DAYS, CMD_YEARS_DIRECT));
    else           w.cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));

    pick = $urandom_range(0, 99);
    if (pick < 45)      w.year = 15'($urandom_range(1890, 2110));
    else if (pick < 70) w.year = 15'($urandom());
    else if (pick < 85) w.year = 15'($urandom_range(32640, 32767));
    else if (pick < 93) w.year = 15'(100 * $urandom_range(0, 327));
    else                w.year = 15'($urandom_range(0, 8));

    w.month = 4'($urandom_range(1, 12));
    pick = $urandom_range(0, 99);
    // Push some dates onto the end of February in a year divisible by four
    if (pick < 10) begin
      w.month = 4'd2;
      w.year  = w.year & 15'h7FFC;
    end
    len = month_length(w.month, w.year);
    if (pick < 35) begin
      w.day = 5'(len);
    end else if (pick < 88) begin
      w.day = 5'($urandom_range(1, 32'(len)));
    end else if (pick < 92) begin
      w.day = 5'd0;
    end else if (pick < 96 || len == 31) begin
      w.month = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
      w.day   = 5'($urandom_range(0, 31));
    end else begin
      w.day = 5'($urandom_range(32'(len) + 1, 31));
    end

    // Keep most counts small; long walks are slow in the block
    pick = $urandom_range(0, 99);
    if (pick < 55)      w.amount = 15'($urandom_range(0, 40));
    else if (pick < 80) w.amount = 15'($urandom_range(0, 1500));
    else if (pick < 92) w.amount = 15'($urandom());
    else if (pick < 96) w.amount = 15'h7FFF;
    else                w.amount = 15'd0;
    return w;
  endfunction

  function automatic int unsigned idle_length(input bit steady);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (steady || pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Hold valid and payload until the word is taken
  task automatic send_word(input date_word_t w);
    in_valid <= 1'b1;
    cmd      <= w.cmd;
    day_in   <= w.day;
    month_in <= w.month;
    year_in  <= w.year;
    amount   <= w.amount;
    do @(posedge clk); while (!in_ready);
    sb.note_word(w);
  endtask

  task automatic idle_sender(input int unsigned cycles);
    if (cycles != 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Drop valid and hold off until every outstanding word is checked
  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_dates.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  initial begin : stimulus
    date_word_t  directed_words[$];
    int unsigned i;
    sb        = new();
    tx_steady = 1'b0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    cmd       <= CMD_DAYS;
    day_in    <= '0;
    month_in  <= '0;
    year_in   <= '0;
    amount    <= '0;

    // Day and week walks: year, leap and century boundaries, ceiling
    directed_words.push_back(make_word(CMD_DAYS, 31, 12, 2023, 1));
    directed_words.push_back(make_word(CMD_DAYS, 28, 2, 2024, 1));
    directed_words.push_back(make_word(CMD_DAYS, 28, 2, 1900, 1));
    directed_words.push_back(make_word(CMD_DAYS, 28, 2, 2000, 1));
    directed_words.push_back(make_word(CMD_DAYS, 1, 1, 0, 32767));
    directed_words.push_back(make_word(CMD_DAYS, 31, 12, 32767, 0));
    directed_words.push_back(make_word(CMD_WEEKS, 15, 6, 32000, 32767));
    directed_words.push_back(make_word(CMD_WEEKS, 25, 12, 32767, 1));
    // Month steps with clamping at short months
    directed_words.push_back(make_word(CMD_MONTHS, 31, 1, 2023, 1));
    directed_words.push_back(make_word(CMD_MONTHS, 31, 1, 2023, 13));
    directed_words.push_back(make_word(CMD_MONTHS, 31, 3, 2000, 30));
    directed_words.push_back(make_word(CMD_MONTHS, 15, 12, 32767, 1));
    directed_words.push_back(make_word(CMD_MONTHS, 1, 1, 0, 32767));
    // Leap day under stepwise and direct year adds, saturation
    directed_words.push_back(make_word(CMD_YEARS_STEP, 29, 2, 2024, 1));
    directed_words.push_back(make_word(CMD_YEARS_STEP, 29, 2, 2024, 4));
    directed_words.push_back(make_word(CMD_YEARS_DIRECT, 29, 2, 2024, 4));
    directed_words.push_back(make_word(CMD_YEARS_DIRECT, 29, 2, 2024, 1));
    directed_words.push_back(make_word(CMD_YEARS_DIRECT, 29, 2, 2000, 32767));
    directed_words.push_back(make_word(CMD_YEARS_STEP, 31, 3, 32700, 100));
    directed_words.push_back(make_word(CMD_YEARS_DIRECT, 29, 2, 2024, 0));
    // Bad dates, and commands the block does not know
    directed_words.push_back(make_word(CMD_DAYS, 1, 0, 2024, 5));
    directed_words.push_back(make_word(CMD_MONTHS, 31, 15, 32767, 32767));
    directed_words.push_back(make_word(CMD_YEARS_STEP, 29, 2, 2023, 1));
    directed_words.push_back(make_word(CMD_SPARE_HI, 0, 4, 2024, 3));
    directed_words.push_back(make_word(CMD_SPARE_LO, 10, 10, 2010, 100));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_words[j]) begin
      send_word(directed_words[j]);
      idle_sender(idle_length(1'b0));
    end
    wait_all_results();

    // Random words, in blocks with and without sender gaps
    for (i = 0; i < RANDOM_WORDS; i++) begin
      tx_steady = ((i / 80) % 3) == 1;
      if (i != 0 && i % DRAIN_EVERY == 0) begin
        wait_all_results();
      end
      send_word(random_word());
      idle_sender(idle_length(tx_steady));
    end

    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_dates.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Output side: check every accepted word, stall at random
  // --------------------------------------------------------------------------
  function automatic int unsigned stall_length();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(0, 2);
    if (pick < 92) return $urandom_range(3, 8);
    return $urandom_range(20, 80);
  endfunction

  function automatic int unsigned ready_length();
    if ($urandom_range(0, 99) < 10) return $urandom_range(200, 400);
    return $urandom_range(0, 20);
  endfunction

  initial begin : result_drain
    int unsigned  run_left;
    date_result_t got;
    run_left  = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got.day    = day_out;
        got.month  = month_out;
        got.year   = year_out;
        got.status = status;
        sb.check_word(got);
      end
      // Alternate ready runs and stalls
      if (run_left != 0) begin
        run_left--;
      end else if (out_ready) begin
        out_ready <= 1'b0;
        run_left = stall_length();
      end else begin
        out_ready <= 1'b1;
        run_left = ready_length();
      end
    end
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/cda_pkg.sv
hdl/cda_useq.sv
hdl/cda_dpath.sv
hdl/calendar_date_adder_core.sv
tb/sv/tb_calendar_date_adder_core.sv
